// File: design/bracket_balance_checker_macros.svh
// ----------------------------------------------------------------------------
// bracket balance checker assertion macros
// shared property forms for the checker of the bracket balance checker
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bracket balance checker: property failed");

// next-cycle implication, sampled on clk, off during reset
`define BBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bracket balance checker: property failed");

`endif

// File: design/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// shared constants, codes and types of the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

  // nesting capacity of the bracket stack
  localparam int MAX_DEPTH = 64;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // character and status widths
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;

  // bracket characters
  localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

  // bracket kind codes
  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;

  // status and latched error codes
  localparam logic [STATUS_W-1:0] ST_BALANCED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLOSER   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  // classified character as it travels from front to back
  typedef struct packed {
    logic              is_open;
    logic              is_close;
    logic [KIND_W-1:0] kind;
    logic              last;
  } bbc_op_t;

endpackage

// File: design/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// accepts characters and classifies them into stack operations
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic                        push,
  input  logic [bbc_pkg::CHAR_W-1:0]  in_character,
  input  logic                        in_last_char,
  input  logic                        q_full,
  output logic                        full,
  output logic                        op_wr,
  output bbc_pkg::bbc_op_t            op
);

  // request handshake toward the operation queue
  assign full  = q_full;
  assign op_wr = push && !q_full;

  // decode opener and closer kinds
  always_comb begin
    op.is_open  = 1'b0;
    op.is_close = 1'b0;
    op.kind     = bbc_pkg::KIND_ROUND;
    op.last     = in_last_char;
    case (in_character)
      bbc_pkg::CH_OPEN_ROUND: begin
        op.is_open = 1'b1;
        op.kind    = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_OPEN_SQUARE: begin
        op.is_open = 1'b1;
        op.kind    = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_OPEN_CURLY: begin
        op.is_open = 1'b1;
        op.kind    = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CH_CLOSE_ROUND: begin
        op.is_close = 1'b1;
        op.kind     = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_CLOSE_SQUARE: begin
        op.is_close = 1'b1;
        op.kind     = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_CLOSE_CURLY: begin
        op.is_close = 1'b1;
        op.kind     = bbc_pkg::KIND_CURLY;
      end
      default: begin
        op.kind = bbc_pkg::KIND_ROUND;
      end
    endcase
  end

endmodule

// File: design/bbc_opq.sv
// ----------------------------------------------------------------------------
// bbc_opq
// two-entry queue of classified operations between front and back
// ----------------------------------------------------------------------------
module bbc_opq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  bbc_pkg::bbc_op_t wr_op,
  output logic             q_full,
  input  logic             rd,
  output logic             rd_valid,
  output bbc_pkg::bbc_op_t rd_op
);

  bbc_pkg::bbc_op_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  // status toward both sides
  assign q_full   = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_op    = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr;
    rd_ptr_nxt = rd_ptr_r ^ rd;
    count_nxt  = count_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

// File: design/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// executes stack operations and forms the end-of-string status
// ----------------------------------------------------------------------------
module bbc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op_valid,
  input  bbc_pkg::bbc_op_t              op,
  output logic                          op_rd,
  output logic                          empty,
  input  logic                          pop,
  output logic [bbc_pkg::STATUS_W-1:0]  out_status
);

  localparam logic [bbc_pkg::DEPTH_W-1:0] DEPTH_MAX = bbc_pkg::DEPTH_W'(bbc_pkg::MAX_DEPTH);
  localparam logic [bbc_pkg::DEPTH_W-1:0] DEPTH_ONE = bbc_pkg::DEPTH_W'(1);
  localparam logic [bbc_pkg::DEPTH_W-1:0] DEPTH_TWO = bbc_pkg::DEPTH_W'(2);

  // entries below the top of stack
  logic [bbc_pkg::KIND_W-1:0]   mem [bbc_pkg::MAX_DEPTH];

  logic [bbc_pkg::DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [bbc_pkg::STATUS_W-1:0] err_r, err_nxt;
  logic [bbc_pkg::KIND_W-1:0]   top_r, top_nxt;
  logic [bbc_pkg::KIND_W-1:0]   below_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [bbc_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic                         fire;
  logic                         do_push, do_pop;
  logic [bbc_pkg::DEPTH_W-1:0]  depth_op;
  logic [bbc_pkg::STATUS_W-1:0] err_op;
  logic                         mem_wr;
  logic [bbc_pkg::DEPTH_W-1:0]  wr_full, rd_full;
  logic [bbc_pkg::ADDR_W-1:0]   wr_addr, rd_addr;

  // take a final operation only when the result slot can accept its status
  assign fire  = op_valid && (!op.last || !out_valid_r || pop);
  assign op_rd = fire;

  assign empty      = !out_valid_r;
  assign out_status = status_r;

  // push, pop and error decision for one operation
  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    depth_op = depth_r;
    err_op   = err_r;
    if (fire && (err_r == bbc_pkg::ST_BALANCED)) begin
      if (op.is_open) begin
        if (depth_r == DEPTH_MAX) begin
          err_op = bbc_pkg::ST_OVERFLOW;
        end else begin
          do_push  = 1'b1;
          depth_op = depth_r + DEPTH_ONE;
        end
      end else if (op.is_close) begin
        if (depth_r == '0 || top_r != op.kind) begin
          err_op = bbc_pkg::ST_CLOSER;
        end else begin
          do_pop   = 1'b1;
          depth_op = depth_r - DEPTH_ONE;
        end
      end
    end
  end

  // end-of-string status and state clear
  always_comb begin
    depth_nxt     = depth_op;
    err_nxt       = err_op;
    out_valid_nxt = out_valid_r && !pop;
    status_nxt    = status_r;
    if (fire && op.last) begin
      out_valid_nxt = 1'b1;
      if (err_op != bbc_pkg::ST_BALANCED) begin
        status_nxt = err_op;
      end else if (depth_op != '0) begin
        status_nxt = bbc_pkg::ST_UNCLOSED;
      end else begin
        status_nxt = bbc_pkg::ST_BALANCED;
      end
      depth_nxt = '0;
      err_nxt   = bbc_pkg::ST_BALANCED;
    end
  end

  // top of stack register
  always_comb begin
    top_nxt = top_r;
    if (do_push) begin
      top_nxt = op.kind;
    end else if (do_pop) begin
      top_nxt = below_r;
    end
  end

  // old top spills to memory on push, next-below entry is read ahead
  assign mem_wr  = do_push && (depth_r != '0);
  assign wr_full = depth_r - DEPTH_ONE;
  assign rd_full = depth_nxt - DEPTH_TWO;
  assign wr_addr = wr_full[bbc_pkg::ADDR_W-1:0];
  assign rd_addr = rd_full[bbc_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_addr] <= top_r;
    end
    if (mem_wr && (wr_addr == rd_addr)) begin
      below_r <= top_r;
    end else begin
      below_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      err_r       <= bbc_pkg::ST_BALANCED;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    status_r <= status_nxt;
  end

endmodule

// File: design/bracket_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker
// checks text strings for balanced round, square and curly brackets
// ----------------------------------------------------------------------------
// One character is taken per clock while the queue is not full. The status
// of a string is registered on the result side when the stack engine takes
// its final character from the queue, as long as the result slot is free; it
// waits there until popped while characters that are not final keep flowing.
// A final character that meets an unpopped status waits in the two-entry
// queue, and once that queue is full the input stalls. The rate is set by the
// stack engine: the top of stack lives in a register and the entry below it
// is read ahead from the single-write stack memory, so no push or pop stalls.
// Status codes: balanced, closer fault, unclosed opener, nesting overflow;
// the first fault of a string wins. No clearing pass is needed after reset.
module bracket_balance_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [bbc_pkg::CHAR_W-1:0]    in_character,
  input  logic                          in_last_char,
  output logic                          empty,
  input  logic                          pop,
  output logic [bbc_pkg::STATUS_W-1:0]  out_status
);

  logic             q_full;
  logic             op_wr;
  bbc_pkg::bbc_op_t op_in;
  logic             op_rd;
  logic             op_valid;
  bbc_pkg::bbc_op_t op_out;

  // character classification
  bbc_front u_front (
    .push         (push),
    .in_character (in_character),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .full         (full),
    .op_wr        (op_wr),
    .op           (op_in)
  );

  // decoupling queue
  bbc_opq u_opq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (op_wr),
    .wr_op    (op_in),
    .q_full   (q_full),
    .rd       (op_rd),
    .rd_valid (op_valid),
    .rd_op    (op_out)
  );

  // stack engine and status output
  bbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (op_valid),
    .op         (op_out),
    .op_rd      (op_rd),
    .empty      (empty),
    .pop        (pop),
    .out_status (out_status)
  );

endmodule

// File: design/bbc_checker.sv
// ----------------------------------------------------------------------------
// bbc_checker
// port-level properties of the bracket balance checker
// ----------------------------------------------------------------------------
`include "bracket_balance_checker_macros.svh"

module bbc_port_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          push,
  input logic                          full,
  input logic [bbc_pkg::CHAR_W-1:0]    in_character,
  input logic                          in_last_char,
  input logic                          empty,
  input logic                          pop,
  input logic [bbc_pkg::STATUS_W-1:0]  out_status
);

  // a waiting status holds until popped
  `BBC_ASSERT_NEXT(a_status_hold, !empty && !pop, !empty && $stable(out_status))

  // both sides come out of reset drained
  `BBC_ASSERT_NOW(a_reset_clear, $past(!rst_n), empty && !full)

  // handshake flags are always driven
  `BBC_ASSERT_NOW(a_flags_known, 1'b1, !$isunknown(full) && !$isunknown(empty))

  // a waiting status carries a defined code
  `BBC_ASSERT_NOW(a_status_known, !empty, !$isunknown(out_status))

endmodule

bind bracket_balance_checker bbc_port_props u_bbc_port_props (.*);
